### src/ilmf_pkg.sv
// ----------------------------------------------------------------------------
// ilmf_pkg
// Shared types and constants for the IN-list membership filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ilmf_pkg;

   localparam int SET_SIZE   = 16;
   localparam int MAX_ARGS   = 4;
   localparam int DATA_WIDTH = 64;

   // fixed item field widths
   localparam int FIELD_W    = 64;
   localparam int ARG_FIELDS = 4;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int ACT_W      = 3;

   localparam int CNT_W = $clog2(SET_SIZE + 1);
   localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int NARGS = (MAX_ARGS < ARG_FIELDS) ? MAX_ARGS : ARG_FIELDS;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_EVAL   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SET_HAS_NULL = 8'd0,
      REG_ACTIVE_ARGS  = 8'd1
   } csr_reg_type;

   // per-item control carried next to the lane compare results
   typedef struct packed {
      logic is_eval;
      logic skip;
      logic err;
      logic cfg_null;
   } s1_ctl_type;

   typedef struct packed {
      logic hit;
      logic nul;
   } lane_out_type;

endpackage : ilmf_pkg

`default_nettype wire

### src/ilmf_if.sv
// ----------------------------------------------------------------------------
// ilmf channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilmf_req_if;
   import ilmf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [FIELD_W-1:0]    value;
   logic                  row_skip;
   logic [FIELD_W-1:0]    arg_a;
   logic [FIELD_W-1:0]    arg_b;
   logic [FIELD_W-1:0]    arg_c;
   logic [FIELD_W-1:0]    arg_d;
   logic [ARG_FIELDS-1:0] arg_null_mask;

   modport source (output valid, op, value, row_skip, arg_a, arg_b, arg_c, arg_d,
                   arg_null_mask, input ready);
   modport sink   (input valid, op, value, row_skip, arg_a, arg_b, arg_c, arg_d,
                   arg_null_mask, output ready);
endinterface : ilmf_req_if

interface ilmf_rsp_if;
   logic valid;
   logic ready;
   logic in_set;
   logic result_null;
   logic set_full_error;

   modport source (output valid, in_set, result_null, set_full_error, input ready);
   modport sink   (input valid, in_set, result_null, set_full_error, output ready);
endinterface : ilmf_rsp_if

interface ilmf_csr_if;
   import ilmf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : ilmf_csr_if

`default_nettype wire

### src/in_list_membership_filter.sv
// Pipeline: the lane compare registers load when a request is accepted, and the
//   merge/output register loads from them when the output can advance.
// Throughput: 1 item per cycle if the output is free; all 16 constants and 4 arguments
//   are compared in parallel lanes; a stalled output still has room for one more item.
// Reset: synchronous, active high; empties the constant set and clears both
//   registers; no clearing pass.
// ----------------------------------------------------------------------------
// in_list_membership_filter
// SQL IN-list predicate over a row stream with a small constant set.
// ----------------------------------------------------------------------------
`default_nettype none

module in_list_membership_filter
   import ilmf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ilmf_req_if.sink   req_ch,
   ilmf_rsp_if.source rsp_ch,
   ilmf_csr_if.sink   csr_ch
);

   logic                                set_has_null_ff;
   logic [ACT_W-1:0]                    active_args_ff;
   logic                                s1_v_ff, s1_v_in;
   s1_ctl_type                          s1_ctl_ff, s1_ctl_in;
   logic                                req_acc, s2_adv, s2_load;
   logic [SET_SIZE-1:0][DATA_WIDTH-1:0] entries;
   logic [SET_SIZE-1:0]                 entry_valid;
   logic                                set_full;
   logic [DATA_WIDTH-1:0]               needle;
   logic [ARG_FIELDS-1:0][FIELD_W-1:0]  args;
   logic [ARG_FIELDS-1:0]               arg_act;
   lane_out_type [SET_SIZE-1:0]         c_lane;
   lane_out_type [ARG_FIELDS-1:0]       a_lane;
   logic [SET_SIZE-1:0]                 const_hit;
   logic [ARG_FIELDS-1:0]               arg_hit, arg_nul;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_has_null_ff <= 1'b0;
         active_args_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_SET_HAS_NULL: set_has_null_ff <= csr_ch.data[0];
            REG_ACTIVE_ARGS:  active_args_ff  <= csr_ch.data[ACT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   assign s2_adv        = !rsp_ch.valid || rsp_ch.ready;
   assign s2_load       = s1_v_ff && s2_adv;
   assign req_ch.ready  = !s1_v_ff || s2_adv;
   assign req_acc       = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_acc) begin
         s1_v_in = 1'b1;
      end else if (s2_adv) begin
         s1_v_in = 1'b0;
      end
   end

   always_comb begin
      s1_ctl_in.is_eval  = (req_ch.op == OP_EVAL);
      s1_ctl_in.skip     = req_ch.row_skip;
      s1_ctl_in.err      = (req_ch.op == OP_INSERT) && set_full;
      s1_ctl_in.cfg_null = set_has_null_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   assign needle = req_ch.value[DATA_WIDTH-1:0];

   ilmf_const_set u_set (
      .clock       (clock),
      .reset       (reset),
      .item_acc    (req_acc),
      .op          (req_ch.op),
      .value       (needle),
      .entries     (entries),
      .entry_valid (entry_valid),
      .full        (set_full)
   );

   for (genvar k = 0; k < SET_SIZE; k++) begin : g_const_lane
      ilmf_lane u_lane (
         .clock   (clock),
         .load    (req_acc),
         .lane_en (entry_valid[k]),
         .is_null (1'b0),
         .needle  (needle),
         .cand    (entries[k]),
         .lane_ff (c_lane[k])
      );
      assign const_hit[k] = c_lane[k].hit;
   end

   assign args = {req_ch.arg_d, req_ch.arg_c, req_ch.arg_b, req_ch.arg_a};

   // argument count saturates at the number of argument lanes
   always_comb begin
      for (int i = 0; i < ARG_FIELDS; i++) begin
         arg_act[i] = (i < NARGS) && (ACT_W'(i) < active_args_ff);
      end
   end

   for (genvar i = 0; i < ARG_FIELDS; i++) begin : g_arg_lane
      ilmf_lane u_lane (
         .clock   (clock),
         .load    (req_acc),
         .lane_en (arg_act[i]),
         .is_null (req_ch.arg_null_mask[i]),
         .needle  (needle),
         .cand    (args[i][DATA_WIDTH-1:0]),
         .lane_ff (a_lane[i])
      );
      assign arg_hit[i] = a_lane[i].hit;
      assign arg_nul[i] = a_lane[i].nul;
   end

   ilmf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (s2_load),
      .ctl       (s1_ctl_ff),
      .const_hit (const_hit),
      .arg_hit   (arg_hit),
      .arg_nul   (arg_nul),
      .rsp       (rsp_ch)
   );

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s2_adv) |-> !req_ch.ready)
      else $error("item taken while both stages are full");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_ch.valid)
      else $error("stage one item lost on its way to the output");

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.set_full_error) |->
         (!rsp_ch.in_set && !rsp_ch.result_null))
      else $error("full-set error on an evaluated row");

endmodule : in_list_membership_filter

`default_nettype wire

### src/ilmf_const_set.sv
// ----------------------------------------------------------------------------
// ilmf_const_set
// Constant store of the IN list: clear, append, full detection.
// ----------------------------------------------------------------------------
`default_nettype none

module ilmf_const_set
   import ilmf_pkg::*;
(
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                item_acc,
   input  wire logic [OP_W-1:0]                     op,
   input  wire logic [DATA_WIDTH-1:0]               value,
   output      logic [SET_SIZE-1:0][DATA_WIDTH-1:0] entries,
   output      logic [SET_SIZE-1:0]                 entry_valid,
   output      logic                                full
);

   logic [SET_SIZE-1:0][DATA_WIDTH-1:0] entry_ff;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                do_clear, do_insert;

   assign full      = (count_ff == CNT_W'(SET_SIZE));
   assign do_clear  = item_acc && (op == OP_CLEAR);
   assign do_insert = item_acc && (op == OP_INSERT) && !full;
   assign entries   = entry_ff;

   always_comb begin
      for (int k = 0; k < SET_SIZE; k++) begin
         entry_valid[k] = (CNT_W'(k) < count_ff);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_clear) begin
         count_in = '0;
      end else if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entries above the count are never looked at, so no reset here
   always_ff @(posedge clock) begin
      if (do_insert) begin
         entry_ff[count_ff[IDX_W-1:0]] <= value;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SET_SIZE))
      else $error("constant count above set size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (count_ff == '0))
      else $error("clear did not empty the set");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (item_acc && (op == OP_INSERT) && full) |=> $stable(count_ff))
      else $error("insert into full set changed the count");

endmodule : ilmf_const_set

`default_nettype wire

### src/ilmf_lane.sv
// ----------------------------------------------------------------------------
// ilmf_lane
// One compare lane: needle against one list value, result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ilmf_lane
   import ilmf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic                  lane_en,
   input  wire logic                  is_null,
   input  wire logic [DATA_WIDTH-1:0] needle,
   input  wire logic [DATA_WIDTH-1:0] cand,
   output      lane_out_type          lane_ff
);

   lane_out_type lane_in;

   always_comb begin
      lane_in.hit = lane_en && !is_null && (needle == cand);
      lane_in.nul = lane_en && is_null;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule : ilmf_lane

`default_nettype wire

### src/ilmf_merge.sv
// ----------------------------------------------------------------------------
// ilmf_merge
// Combines lane results into the three-valued predicate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilmf_merge
   import ilmf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire s1_ctl_type            ctl,
   input  wire logic [SET_SIZE-1:0]   const_hit,
   input  wire logic [ARG_FIELDS-1:0] arg_hit,
   input  wire logic [ARG_FIELDS-1:0] arg_nul,
   ilmf_rsp_if.source                 rsp
);

   logic valid_ff, valid_in;
   logic in_set_ff, in_set_in;
   logic null_ff, null_in;
   logic err_ff;
   logic match;

   assign match     = ctl.skip || (|const_hit) || (|arg_hit);
   assign in_set_in = ctl.is_eval && match;
   assign null_in   = ctl.is_eval &&
                      (ctl.skip || (!match && (ctl.cfg_null || (|arg_nul))));

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_set_ff <= in_set_in;
         null_ff   <= null_in;
         err_ff    <= ctl.err;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.in_set         = in_set_ff;
   assign rsp.result_null    = null_ff;
   assign rsp.set_full_error = err_ff;

endmodule : ilmf_merge

`default_nettype wire
